// ===== design/smas_pkg.sv =====
// ----------------------------------------------------------------------------
// smas_pkg
// Shared constants for the small matrix add / subtract / multiply block:
// field widths, command and mode codes, register indexes, datapath widths.
// ----------------------------------------------------------------------------
package smas_pkg;

	// default and hard limit of the matrix dimension
	localparam int MAX_DIM_DEF = 8;
	localparam int IDX_LIMIT   = 8;

	// word field widths
	localparam int OP_W   = 2;
	localparam int IDX_W  = 3;
	localparam int ELEM_W = 16;
	localparam int RES_W  = 32;

	// configuration register widths
	localparam int MODE_W = 2;
	localparam int DIM_W  = 4;

	// datapath: one Q16.16 term, and the accumulator of up to eight terms
	localparam int PROD_W = 32;
	localparam int ACC_W  = 40;

	// APB port
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 32;

	// command codes
	localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
	localparam logic [OP_W-1:0] OP_RUN     = 2'd2;

	// operation modes
	localparam logic [MODE_W-1:0] MODE_ADD = 2'd0;
	localparam logic [MODE_W-1:0] MODE_SUB = 2'd1;
	localparam logic [MODE_W-1:0] MODE_MUL = 2'd2;

	// register indexes
	localparam logic [2:0] REG_OP_MODE = 3'd0;
	localparam logic [2:0] REG_ROWS_A  = 3'd1;
	localparam logic [2:0] REG_COLS_A  = 3'd2;
	localparam logic [2:0] REG_ROWS_B  = 3'd3;
	localparam logic [2:0] REG_COLS_B  = 3'd4;

endpackage

// ===== design/smas_if.sv =====
// ----------------------------------------------------------------------------
// smas_if
// Valid/ready channels of the matrix block: the command word going in and
// the result word coming out.
// ----------------------------------------------------------------------------

// command word: element load or run
interface smas_cmd_if import smas_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [OP_W-1:0]          operation;
	logic [IDX_W-1:0]         row_index;
	logic [IDX_W-1:0]         col_index;
	logic signed [ELEM_W-1:0] element_value;

	modport source (output valid, operation, row_index, col_index, element_value,
		input ready);
	modport sink (input valid, operation, row_index, col_index, element_value,
		output ready);
endinterface

// result word: one element of C, or the error word
interface smas_res_if import smas_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        out_row;
	logic [IDX_W-1:0]        out_col;
	logic signed [RES_W-1:0] out_value;
	logic                    last;
	logic                    dim_error;

	modport source (output valid, out_row, out_col, out_value, last, dim_error,
		input ready);
	modport sink (input valid, out_row, out_col, out_value, last, dim_error,
		output ready);
endinterface

// ===== design/small_matrix_add_sub_multiply.sv =====
// ----------------------------------------------------------------------------
// small_matrix_add_sub_multiply
// Holds matrices A and B (signed Q8.8) and streams A+B, A-B or A*B as
// saturated signed Q16.16 words in row-major order.
// ----------------------------------------------------------------------------
// Element load words are taken back to back while the block is idle. A run
// word keeps the block busy (cmd.ready low) until its last result word has
// been taken. Results come from the single multiply-accumulate unit and the
// one read port of each store: while an element is computed, one term
// enters the accumulator per cycle, and the next element starts only after
// the result word has been taken. A shape mismatch, or mode 3, returns one
// error word (last and dim_error set) from the result register. Dimension
// registers of 0 are used as 1 and values above min(MAX_DIM, 8) as that
// bound; readback returns the stored value. Entries of A or B never loaded
// return undefined data.
// ----------------------------------------------------------------------------
module small_matrix_add_sub_multiply import smas_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	smas_cmd_if.sink           cmd,
	smas_res_if.source         result
);

	localparam int DEPTH     = MAX_DIM * MAX_DIM;
	localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int DIM_BOUND = (MAX_DIM < IDX_LIMIT) ? MAX_DIM : IDX_LIMIT;
	localparam logic [DIM_W-1:0] BOUND_L = DIM_W'(DIM_BOUND);
	localparam logic [4:0]       MAXD_L  = 5'(MAX_DIM);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_WAIT,
		ST_OUT
	} state_t;

	// clamp a dimension register to 1..DIM_BOUND
	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
		logic [DIM_W-1:0] r;
		r = d;
		if (d == '0)
			r = DIM_W'(1);
		else if (d > BOUND_L)
			r = BOUND_L;
		return r;
	endfunction

	// store address of an element
	function automatic logic [AW-1:0] elem_addr(input logic [IDX_W-1:0] r,
		input logic [IDX_W-1:0] c);
		return AW'(int'(r) * MAX_DIM + int'(c));
	endfunction

	// ------------------------------------------------------------------------
	// configuration registers
	// ------------------------------------------------------------------------
	logic [MODE_W-1:0] op_mode_q;
	logic [DIM_W-1:0]  rows_a_q, cols_a_q, rows_b_q, cols_b_q;
	logic [2:0]        reg_idx;
	logic              cfg_wr;

	assign reg_idx = paddr[4:2];
	assign cfg_wr  = psel & penable & pwrite;
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_mode_q <= MODE_ADD;
			rows_a_q  <= DIM_W'(8);
			cols_a_q  <= DIM_W'(8);
			rows_b_q  <= DIM_W'(8);
			cols_b_q  <= DIM_W'(8);
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_OP_MODE: op_mode_q <= pwdata[MODE_W-1:0];
				REG_ROWS_A:  rows_a_q  <= pwdata[DIM_W-1:0];
				REG_COLS_A:  cols_a_q  <= pwdata[DIM_W-1:0];
				REG_ROWS_B:  rows_b_q  <= pwdata[DIM_W-1:0];
				REG_COLS_B:  cols_b_q  <= pwdata[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (reg_idx)
			REG_OP_MODE: prdata = PDATA_W'(op_mode_q);
			REG_ROWS_A:  prdata = PDATA_W'(rows_a_q);
			REG_COLS_A:  prdata = PDATA_W'(cols_a_q);
			REG_ROWS_B:  prdata = PDATA_W'(rows_b_q);
			REG_COLS_B:  prdata = PDATA_W'(cols_b_q);
			default:     prdata = '0;
		endcase
	end

	// ------------------------------------------------------------------------
	// effective shapes and run checks
	// ------------------------------------------------------------------------
	logic [DIM_W-1:0] ra, ca, rb, cb, n_cols, k_len;
	logic             is_mul, shape_err;

	assign ra     = clamp_dim(rows_a_q);
	assign ca     = clamp_dim(cols_a_q);
	assign rb     = clamp_dim(rows_b_q);
	assign cb     = clamp_dim(cols_b_q);
	assign is_mul = (op_mode_q == MODE_MUL);
	assign n_cols = is_mul ? cb : ca;
	assign k_len  = is_mul ? ca : DIM_W'(1);

	always_comb begin
		case (op_mode_q)
			MODE_ADD, MODE_SUB: shape_err = (ra != rb) || (ca != cb);
			MODE_MUL:           shape_err = (ca != rb);
			default:            shape_err = 1'b1;
		endcase
	end

	// ------------------------------------------------------------------------
	// sequencer state
	// ------------------------------------------------------------------------
	state_t           state_q;
	logic [IDX_W-1:0] i_q, j_q, k_q;
	logic             i_end, j_end, k_end;

	assign i_end = (i_q == IDX_W'(ra - DIM_W'(1)));
	assign j_end = (j_q == IDX_W'(n_cols - DIM_W'(1)));
	assign k_end = (k_q == IDX_W'(k_len - DIM_W'(1)));

	// ------------------------------------------------------------------------
	// element stores: load port and one registered read port each
	// ------------------------------------------------------------------------
	logic [ELEM_W-1:0] store_a [DEPTH];
	logic [ELEM_W-1:0] store_b [DEPTH];
	logic [AW-1:0]     wr_addr, rd_addr_a, rd_addr_b;
	logic              cmd_take, in_range, wr_a, wr_b;
	logic signed [ELEM_W-1:0] rd_a_s1, rd_b_s1;

	assign cmd.ready = (state_q == ST_IDLE);
	assign cmd_take  = cmd.valid & cmd.ready;
	assign in_range  = ({2'b00, cmd.row_index} < MAXD_L) &&
		({2'b00, cmd.col_index} < MAXD_L);
	assign wr_a      = cmd_take && in_range && (cmd.operation == OP_WRITE_A);
	assign wr_b      = cmd_take && in_range && (cmd.operation == OP_WRITE_B);
	assign wr_addr   = elem_addr(cmd.row_index, cmd.col_index);

	// multiply walks row i of A and column j of B; add/sub reads (i, j)
	assign rd_addr_a = is_mul ? elem_addr(i_q, k_q) : elem_addr(i_q, j_q);
	assign rd_addr_b = is_mul ? elem_addr(k_q, j_q) : elem_addr(i_q, j_q);

	always_ff @(posedge clk) begin
		if (wr_a)
			store_a[wr_addr] <= cmd.element_value;
		rd_a_s1 <= store_a[rd_addr_a];
	end

	always_ff @(posedge clk) begin
		if (wr_b)
			store_b[wr_addr] <= cmd.element_value;
		rd_b_s1 <= store_b[rd_addr_b];
	end

	// ------------------------------------------------------------------------
	// shared arithmetic unit: term stage and accumulator
	// ------------------------------------------------------------------------
	logic                     valid_s1, first_s1, last_s1;
	logic                     valid_s2, first_s2, last_s2;
	logic signed [PROD_W-1:0] term_s2;
	logic signed [ACC_W-1:0]  acc_q;
	logic                     fin_q;
	logic signed [ELEM_W:0]   sum_ab;

	// Q9.8 sum or difference of the Q8.8 elements, 17 bits
	assign sum_ab = (op_mode_q == MODE_SUB) ?
		(ELEM_W+1)'(rd_a_s1) - (ELEM_W+1)'(rd_b_s1) :
		(ELEM_W+1)'(rd_a_s1) + (ELEM_W+1)'(rd_b_s1);

	always_ff @(posedge clk) begin
		if (is_mul)
			term_s2 <= PROD_W'(rd_a_s1 * rd_b_s1);
		else
			term_s2 <= PROD_W'(sum_ab) <<< 8;
		if (valid_s2)
			acc_q <= first_s2 ? ACC_W'(term_s2) : acc_q + ACC_W'(term_s2);
	end

	// tags that travel with the read data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			first_s1 <= 1'b0;
			last_s1  <= 1'b0;
			valid_s2 <= 1'b0;
			first_s2 <= 1'b0;
			last_s2  <= 1'b0;
			fin_q    <= 1'b0;
		end else begin
			valid_s1 <= (state_q == ST_CALC);
			first_s1 <= (k_q == '0);
			last_s1  <= k_end;
			valid_s2 <= valid_s1;
			first_s2 <= first_s1;
			last_s2  <= last_s1;
			fin_q    <= valid_s2 & last_s2;
		end
	end

	// saturate the accumulator to 32 bits
	logic signed [RES_W-1:0] sat_val;
	logic                    acc_fits;

	assign acc_fits = (acc_q[ACC_W-1:RES_W-1] == '0) ||
		(acc_q[ACC_W-1:RES_W-1] == '1);

	always_comb begin
		if (acc_fits)
			sat_val = acc_q[RES_W-1:0];
		else if (acc_q[ACC_W-1])
			sat_val = {1'b1, {(RES_W-1){1'b0}}};
		else
			sat_val = {1'b0, {(RES_W-1){1'b1}}};
	end

	// ------------------------------------------------------------------------
	// sequencer and result register
	// ------------------------------------------------------------------------
	logic                    res_valid_q, res_last_q, res_err_q;
	logic [IDX_W-1:0]        res_row_q, res_col_q;
	logic signed [RES_W-1:0] res_value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			i_q         <= '0;
			j_q         <= '0;
			k_q         <= '0;
			res_valid_q <= 1'b0;
			res_last_q  <= 1'b0;
			res_err_q   <= 1'b0;
			res_row_q   <= '0;
			res_col_q   <= '0;
			res_value_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd_take && cmd.operation == OP_RUN) begin
						i_q <= '0;
						j_q <= '0;
						k_q <= '0;
						if (shape_err) begin
							res_valid_q <= 1'b1;
							res_last_q  <= 1'b1;
							res_err_q   <= 1'b1;
							res_row_q   <= '0;
							res_col_q   <= '0;
							res_value_q <= '0;
							state_q     <= ST_OUT;
						end else begin
							state_q <= ST_CALC;
						end
					end
				end
				// one term read per cycle
				ST_CALC: begin
					if (k_end) begin
						k_q     <= '0;
						state_q <= ST_WAIT;
					end else begin
						k_q <= k_q + IDX_W'(1);
					end
				end
				// wait for the last term to land in the accumulator
				ST_WAIT: begin
					if (fin_q) begin
						res_valid_q <= 1'b1;
						res_last_q  <= i_end & j_end;
						res_err_q   <= 1'b0;
						res_row_q   <= i_q;
						res_col_q   <= j_q;
						res_value_q <= sat_val;
						state_q     <= ST_OUT;
					end
				end
				// hold the word until taken, then step to the next element
				ST_OUT: begin
					if (result.ready) begin
						res_valid_q <= 1'b0;
						if (res_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							if (j_end) begin
								j_q <= '0;
								i_q <= i_q + IDX_W'(1);
							end else begin
								j_q <= j_q + IDX_W'(1);
							end
							state_q <= ST_CALC;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign result.valid     = res_valid_q;
	assign result.out_row   = res_row_q;
	assign result.out_col   = res_col_q;
	assign result.out_value = res_value_q;
	assign result.last      = res_last_q;
	assign result.dim_error = res_err_q;

endmodule
